FILE: hdl/lz77_dictionary_match_expander_unit_defines.svh
// Assertion macros shared by the checker of the LZ77 match expander.
`ifndef LZ77_DICTIONARY_MATCH_EXPANDER_UNIT_DEFINES_SVH
`define LZ77_DICTIONARY_MATCH_EXPANDER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define LZME_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define LZME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/lzme_pkg.sv
// Shared types and constants of the LZ77 match expander.
package lzme_pkg;

   // Field widths of a request
   localparam int DATA_W = 8;
   localparam int DIST_W = 16;
   localparam int LEN_W  = 7;
   localparam int KIND_W = 2;

   // Request kinds as carried on the request tuser
   localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MATCH   = 2'd2;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // Commands the back end carries out
   typedef enum logic [1:0] {
      OP_STORE = 2'd0,   // store byte, no result
      OP_EMIT  = 2'd1,   // store byte and emit it
      OP_COPY  = 2'd2,   // copy from history
      OP_ERROR = 2'd3    // single error result
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [DATA_W-1:0]   data;
      logic [DIST_W-1:0]   distance;
      logic [LEN_W-1:0]    len;
   } cmd_type;

endpackage

FILE: hdl/lzme_ram.sv
// Generic simple dual-port RAM with registered read data.
module lzme_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/lzme_front.sv
// Front end: classify requests, track the stored byte count, issue commands.
module lzme_front #(
   parameter int WINDOW_SIZE = 32768,
   parameter int MAX_MATCH   = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lzme_pkg::KIND_W-1:0]   req_kind,
   input  logic [lzme_pkg::DATA_W-1:0]   req_data,
   input  logic [lzme_pkg::DIST_W-1:0]   req_dist,
   input  logic [lzme_pkg::LEN_W-1:0]    req_len,
   output logic                          push_valid,
   input  logic                          push_ready,
   output lzme_pkg::cmd_type             push_cmd
);

   localparam int CW   = $clog2(WINDOW_SIZE + 1);
   localparam int CMPW = (CW > lzme_pkg::DIST_W) ? CW : lzme_pkg::DIST_W;
   localparam logic [CW:0] WIN_SUM = (CW + 1)'(WINDOW_SIZE);

   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;
   logic                      accept;
   logic                      dist_bad;
   logic [lzme_pkg::LEN_W-1:0] len_clamp;
   logic [CW:0]               add_amount;
   logic [CW:0]               count_sum;
   logic                      keep;
   lzme_pkg::op_type          op;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;

   // Check distance against bytes stored so far, clamp length
   assign dist_bad  = (req_dist == '0) || (CMPW'(req_dist) > CMPW'(count_ff));
   assign len_clamp = (req_len > lzme_pkg::LEN_W'(MAX_MATCH)) ?
                      lzme_pkg::LEN_W'(MAX_MATCH) : req_len;

   // Classify the request
   always_comb begin
      op         = lzme_pkg::OP_STORE;
      keep       = 1'b0;
      add_amount = '0;
      case (req_kind)
         lzme_pkg::KIND_LOAD: begin
            op         = lzme_pkg::OP_STORE;
            keep       = 1'b1;
            add_amount = (CW + 1)'(1);
         end
         lzme_pkg::KIND_LITERAL: begin
            op         = lzme_pkg::OP_EMIT;
            keep       = 1'b1;
            add_amount = (CW + 1)'(1);
         end
         lzme_pkg::KIND_MATCH: begin
            if (dist_bad) begin
               op   = lzme_pkg::OP_ERROR;
               keep = 1'b1;
            end else begin
               op         = lzme_pkg::OP_COPY;
               keep       = (len_clamp != '0);
               add_amount = (CW + 1)'(len_clamp);
            end
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push_valid        = req_valid && keep;
   assign push_cmd.op       = op;
   assign push_cmd.data     = req_data;
   assign push_cmd.distance = req_dist;
   assign push_cmd.len      = len_clamp;

   // Advance the stored count, saturating at the window size
   assign count_sum = {1'b0, count_ff} + add_amount;
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = (count_sum > WIN_SUM) ? CW'(WINDOW_SIZE) : count_sum[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: hdl/lzme_cmd_fifo.sv
// Short command queue between front and back end.
module lzme_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  lzme_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output lzme_pkg::cmd_type pop_cmd
);

   localparam int QW = lzme_pkg::QPTR_W;

   lzme_pkg::cmd_type entry_ff [lzme_pkg::QUEUE_DEPTH];
   logic [QW-1:0]     wr_ptr_ff;
   logic [QW-1:0]     wr_ptr_in;
   logic [QW-1:0]     rd_ptr_ff;
   logic [QW-1:0]     rd_ptr_in;
   logic [QW:0]       fill_ff;
   logic [QW:0]       fill_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (fill_ff != (QW + 1)'(lzme_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (QW + 1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (QW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hdl/lzme_back.sv
// Back end: history ring, copy sequencer and result register.
module lzme_back #(
   parameter int WINDOW_SIZE = 32768
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   output logic                        cmd_ready,
   input  lzme_pkg::cmd_type           cmd,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [lzme_pkg::DATA_W-1:0] rsp_byte,
   output logic                        rsp_last,
   output logic                        rsp_error
);

   localparam int AW = $clog2(WINDOW_SIZE);
   localparam int LW = $clog2(lzme_pkg::LEN_W'(1) << (lzme_pkg::LEN_W - 1)) + 1;
   localparam int XW = ((AW > lzme_pkg::DIST_W) ? AW : lzme_pkg::DIST_W) + 2;
   localparam logic [XW-1:0] WIN_X  = XW'(WINDOW_SIZE);
   localparam logic [AW-1:0] LAST_A = AW'(WINDOW_SIZE - 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_READ  = 3'b010,
      ST_WRITE = 3'b100
   } back_state_type;

   back_state_type              state_ff, state_in;
   logic [AW-1:0]               wp_ff, wp_in;
   logic [AW-1:0]               rp_ff, rp_in;
   logic [LW-1:0]               left_ff, left_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [lzme_pkg::DATA_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_error_ff, rsp_error_in;

   logic                        out_free;
   logic [XW-1:0]               start_sum;
   logic [XW-1:0]               start_wrap;
   logic [AW-1:0]               start_rp;
   logic                        ram_wr_en;
   logic [lzme_pkg::DATA_W-1:0] ram_wr_data;
   logic                        ram_rd_en;
   logic [lzme_pkg::DATA_W-1:0] ram_rd_data;

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
      ring_next = (p == LAST_A) ? '0 : p + AW'(1);
   endfunction

   lzme_ram #(
      .WIDTH (lzme_pkg::DATA_W),
      .DEPTH (WINDOW_SIZE)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rp_ff),
      .rd_data (ram_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   // First read position of a copy: write pointer minus distance, modulo window
   assign start_sum  = XW'(wp_ff) + WIN_X - XW'(cmd.distance);
   assign start_wrap = start_sum - WIN_X;
   assign start_rp   = (start_sum >= WIN_X) ? start_wrap[AW-1:0] : start_sum[AW-1:0];

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_error_in = rsp_error_ff;
      cmd_ready    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_data  = cmd.data;
      ram_rd_en    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            case (cmd.op)
               lzme_pkg::OP_STORE: begin
                  cmd_ready = 1'b1;
                  if (cmd_valid) begin
                     ram_wr_en = 1'b1;
                     wp_in     = ring_next(wp_ff);
                  end
               end
               lzme_pkg::OP_EMIT: begin
                  cmd_ready = out_free;
                  if (cmd_valid && out_free) begin
                     ram_wr_en    = 1'b1;
                     wp_in        = ring_next(wp_ff);
                     rsp_valid_in = 1'b1;
                     rsp_byte_in  = cmd.data;
                     rsp_last_in  = 1'b1;
                     rsp_error_in = 1'b0;
                  end
               end
               lzme_pkg::OP_COPY: begin
                  cmd_ready = 1'b1;
                  if (cmd_valid) begin
                     rp_in    = start_rp;
                     left_in  = cmd.len[LW-1:0];
                     state_in = ST_READ;
                  end
               end
               default: begin
                  cmd_ready = out_free;
                  if (cmd_valid && out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_byte_in  = '0;
                     rsp_last_in  = 1'b1;
                     rsp_error_in = 1'b1;
                  end
               end
            endcase
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            ram_wr_data = ram_rd_data;
            if (out_free) begin
               ram_wr_en    = 1'b1;
               wp_in        = ring_next(wp_ff);
               rp_in        = ring_next(rp_ff);
               left_in      = left_ff - LW'(1);
               rsp_valid_in = 1'b1;
               rsp_byte_in  = ram_rd_data;
               rsp_last_in  = (left_ff == LW'(1));
               rsp_error_in = 1'b0;
               state_in     = (left_ff == LW'(1)) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rp_ff        <= rp_in;
      left_ff      <= left_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte  = rsp_byte_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_error = rsp_error_ff;

endmodule

FILE: hdl/lz77_dictionary_match_expander_unit.sv
// Top level of the LZ77 expander with preset dictionary.
// Requests enter a classifier that checks each match distance against the number of
// bytes stored so far and queues a command (up to four) for the back end, so the request
// side keeps flowing while results are stalled, until the queue is full. The back end
// owns the history ring, a single RAM of WINDOW_SIZE bytes with one write and one
// registered read port; it is not cleared after reset and is ready at once. A dictionary
// load, a literal and a rejected match are handled in the idle state; each copied byte
// of a match is read in the read state, then written back and registered as a result in
// the write state. Requests of kind 3 and valid matches of length 0 leave no trace.
module lz77_dictionary_match_expander_unit #(
   parameter int WINDOW_SIZE = 32768,
   parameter int MAX_MATCH   = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // data_byte[7:0], match_distance[23:8], match_length[30:24]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte[7:0]
   output logic        rsp_tlast,
   output logic        rsp_tuser    // error[0]
);

   logic              push_valid;
   logic              push_ready;
   lzme_pkg::cmd_type push_cmd;
   logic              pop_valid;
   logic              pop_ready;
   lzme_pkg::cmd_type pop_cmd;

   // Classify requests
   lzme_front #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .MAX_MATCH   (MAX_MATCH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_tuser),
      .req_data   (req_tdata[7:0]),
      .req_dist   (req_tdata[23:8]),
      .req_len    (req_tdata[30:24]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // Queue commands
   lzme_cmd_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // Carry out commands against the history
   lzme_back #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd       (pop_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_byte  (rsp_tdata),
      .rsp_last  (rsp_tlast),
      .rsp_error (rsp_tuser)
   );

endmodule

FILE: hdl/lzme_checker.sv
// Port checker of the LZ77 expander and its bind to the top level.
`include "lz77_dictionary_match_expander_unit_defines.svh"

module lzme_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // Hold a stalled result
   `LZME_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled result changed")

   // An error result closes its request
   `LZME_ASSERT_NOW(a_err_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast, "error result without last")

   // An error result carries no byte
   `LZME_ASSERT_NOW(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == 8'd0, "error result with nonzero byte")

   // A result taken after an error result starts a new request
   `LZME_ASSERT_NEXT(a_err_alone, clock, reset, rsp_tvalid && rsp_tready && rsp_tuser, !rsp_tvalid || !$stable(rsp_tuser) || rsp_tlast, "error result followed by a partial request")

endmodule

bind lz77_dictionary_match_expander_unit lzme_checker u_lzme_checker (.*);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the LZ77 dictionary match expander.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW          = 32768;
   localparam int MATCH_CAP       = 64;
   localparam int RANDOM_ITEMS    = 290;
   localparam int DEEP_MATCHES    = 40;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DIRECTED_ROWS   = 22;

   // Request kind the block ignores
   localparam logic [lzme_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   // One decoded result as seen on the result channel
   typedef struct packed {
      logic [lzme_pkg::DATA_W-1:0] out_byte;
      logic                        last;
      logic                        error;
   } decoded_type;

   // One directed request, with a typed expectation where it is obvious
   typedef struct packed {
      logic [lzme_pkg::KIND_W-1:0] kind;
      logic [lzme_pkg::DATA_W-1:0] data;
      logic [lzme_pkg::DIST_W-1:0] distance;
      logic [lzme_pkg::LEN_W-1:0]  len;
      logic                        typed;
      logic [lzme_pkg::DATA_W-1:0] want_byte;
      logic                        want_last;
      logic                        want_error;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // data_byte[7:0], match_distance[23:8], match_length[30:24]
   logic [1:0]  req_tuser;   // req_type[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // out_byte[7:0]
   logic        rsp_tlast;
   logic        rsp_tuser;   // error[0]

   // Predicted history ring and its bookkeeping
   logic [lzme_pkg::DATA_W-1:0] history_ram [WINDOW];
   int unsigned                 write_pos;
   int unsigned                 bytes_held;
   decoded_type                 expected_bytes [$];

   int failures;
   bit req_calm;
   bit rsp_calm;
   bit hold_off_request;
   int stalled_cycles;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{lzme_pkg::KIND_MATCH,   8'h00, 16'd1,    7'd1,   1'b1, 8'h00, 1'b1, 1'b1},
      '{lzme_pkg::KIND_MATCH,   8'hFF, 16'd0,    7'd5,   1'b1, 8'h00, 1'b1, 1'b1},
      '{lzme_pkg::KIND_LOAD,    8'h00, 16'd0,    7'd0,   1'b0, 8'h00, 1'b0, 1'b0},
      '{lzme_pkg::KIND_LOAD,    8'hFF, 16'hFFFF, 7'h7F,  1'b0, 8'h00, 1'b0, 1'b0},
      '{lzme_pkg::KIND_LOAD,    8'hA5, 16'd3,    7'd2,   1'b0, 8'h00, 1'b0, 1'b0},
      '{lzme_pkg::KIND_MATCH,   8'h00, 16'd4,    7'd3,   1'b1, 8'h00, 1'b1, 1'b1},
      '{lzme_pkg::KIND_MATCH,   8'h00, 16'd3,    7'd2,   1'b0, 8'h00, 1'b0, 1'b0},
      '{lzme_pkg::KIND_LITERAL, 8'hFF, 16'd0,    7'd0,   1'b1, 8'hFF, 1'b1, 1'b0},
      '{lzme_pkg::KIND_LITERAL, 8'h00, 16'hFFFF, 7'h7F,  1'b1, 8'h00, 1'b1, 1'b0},
      '{lzme_pkg::KIND_MATCH,   8'h77, 16'd1,    7'd0,   1'b0, 8'h00, 1'b0, 1'b0},
      '{lzme_pkg::KIND_MATCH,   8'h00, 16'd1,    7'd127, 1'b0, 8'h00, 1'b0, 1'b0},
      '{lzme_pkg::KIND_MATCH,   8'h00, 16'd2,    7'd64,  1'b0, 8'h00, 1'b0, 1'b0},
      '{lzme_pkg::KIND_MATCH,   8'h00, 16'hFFFF, 7'd1,   1'b1, 8'h00, 1'b1, 1'b1},
      '{lzme_pkg::KIND_MATCH,   8'h00, 16'h8000, 7'd7,   1'b1, 8'h00, 1'b1, 1'b1},
      '{KIND_UNUSED,            8'hFF, 16'hFFFF, 7'h7F,  1'b0, 8'h00, 1'b0, 1'b0},
      '{lzme_pkg::KIND_LOAD,    8'h5A, 16'd0,    7'd0,   1'b0, 8'h00, 1'b0, 1'b0},
      '{lzme_pkg::KIND_MATCH,   8'h00, 16'd5,    7'd5,   1'b0, 8'h00, 1'b0, 1'b0},
      '{lzme_pkg::KIND_MATCH,   8'h00, 16'd141,  7'd64,  1'b0, 8'h00, 1'b0, 1'b0},
      '{lzme_pkg::KIND_MATCH,   8'h00, 16'd206,  7'd1,   1'b1, 8'h00, 1'b1, 1'b1},
      '{lzme_pkg::KIND_LITERAL, 8'h80, 16'd0,    7'd0,   1'b1, 8'h80, 1'b1, 1'b0},
      '{lzme_pkg::KIND_MATCH,   8'h00, 16'd1,    7'd64,  1'b0, 8'h00, 1'b0, 1'b0},
      '{lzme_pkg::KIND_MATCH,   8'h00, 16'd3,    7'd65,  1'b0, 8'h00, 1'b0, 1'b0}
   };

   lz77_dictionary_match_expander_unit #(
      .WINDOW_SIZE (WINDOW),
      .MAX_MATCH   (MATCH_CAP)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Add one expected result at the tail of the queue
   function automatic void queue_result(input decoded_type result);
      expected_bytes.insert(expected_bytes.size(), result);
   endfunction

   // Append one byte to the predicted history
   function automatic void append_history(input logic [lzme_pkg::DATA_W-1:0] value);
      history_ram[write_pos] = value;
      write_pos = (write_pos + 1) % WINDOW;
      if (bytes_held < WINDOW)
         bytes_held++;
   endfunction

   // Work out the decoded bytes of one request; record them when asked
   function automatic void expand_request(input logic [lzme_pkg::KIND_W-1:0] kind,
                                          input logic [lzme_pkg::DATA_W-1:0] data,
                                          input logic [lzme_pkg::DIST_W-1:0] distance,
                                          input logic [lzme_pkg::LEN_W-1:0]  len,
                                          input bit                          record);
      int unsigned                 count;
      int unsigned                 rd;
      logic [lzme_pkg::DATA_W-1:0] value;
      case (kind)
         lzme_pkg::KIND_LOAD: begin
            append_history(data);
         end
         lzme_pkg::KIND_LITERAL: begin
            append_history(data);
            if (record)
               queue_result('{data, 1'b1, 1'b0});
         end
         lzme_pkg::KIND_MATCH: begin
            if (distance == 0 || distance > bytes_held) begin
               if (record)
                  queue_result('{8'h00, 1'b1, 1'b1});
            end else begin
               count = (len > MATCH_CAP) ? MATCH_CAP : len;
               // copy byte by byte so an overlapping copy repeats the run
               for (int unsigned i = 0; i < count; i++) begin
                  rd = (write_pos + WINDOW - distance) % WINDOW;
                  value = history_ram[rd];
                  append_history(value);
                  if (record)
                     queue_result('{value, (i + 1 == count), 1'b0});
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Offer one request, hold it until taken, then predict its results
   task automatic send_request(input logic [lzme_pkg::KIND_W-1:0] kind,
                               input logic [lzme_pkg::DATA_W-1:0] data,
                               input logic [lzme_pkg::DIST_W-1:0] distance,
                               input logic [lzme_pkg::LEN_W-1:0]  len,
                               input bit                          typed,
                               input decoded_type                 typed_result);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, len, distance, data};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      expand_request(kind, data, distance, len, !typed);
      if (typed)
         queue_result(typed_result);
   endtask

   // Stimulus: directed table, random requests, then far matches
   initial begin
      logic [lzme_pkg::KIND_W-1:0] kind;
      logic [lzme_pkg::DATA_W-1:0] data;
      logic [lzme_pkg::DIST_W-1:0] distance;
      logic [lzme_pkg::LEN_W-1:0]  len;
      int unsigned                 reach;
      int                          pick;
      int                          roll;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = '0;
      failures         = 0;
      req_calm         = 1'b0;
      rsp_calm         = 1'b0;
      hold_off_request = 1'b0;
      write_pos        = 0;
      bytes_held       = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (directed_rows[r])
         send_request(directed_rows[r].kind, directed_rows[r].data,
                      directed_rows[r].distance, directed_rows[r].len,
                      directed_rows[r].typed,
                      '{directed_rows[r].want_byte, directed_rows[r].want_last,
                        directed_rows[r].want_error});

      // random requests: loads, literals and valid matches over the growing history, plus noise
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            req_calm = ($urandom_range(0, 3) == 0);
            rsp_calm = ($urandom_range(0, 3) == 0);
         end
         if (n == 120)
            hold_off_request = 1'b1;
         data     = lzme_pkg::DATA_W'($urandom);
         distance = lzme_pkg::DIST_W'($urandom);
         len      = lzme_pkg::LEN_W'($urandom);
         pick     = $urandom_range(0, 99);
         if (pick < 15) begin
            kind = lzme_pkg::KIND_LOAD;
         end else if (pick < 45) begin
            kind = lzme_pkg::KIND_LITERAL;
         end else if (pick < 90 && bytes_held > 0) begin
            kind  = lzme_pkg::KIND_MATCH;
            roll  = $urandom_range(0, 9);
            reach = (roll < 6) ? 16 : (roll < 9) ? 300 : bytes_held;
            if (reach > bytes_held)
               reach = bytes_held;
            distance = lzme_pkg::DIST_W'($urandom_range(1, reach));
            roll = $urandom_range(0, 19);
            len  = (roll < 16) ? lzme_pkg::LEN_W'($urandom_range(1, 8)) :
                   (roll < 19) ? lzme_pkg::LEN_W'($urandom_range(9, 64)) :
                                 lzme_pkg::LEN_W'($urandom_range(65, 127));
         end else begin
            // noise: ignored kind, bad distances, empty matches
            kind = lzme_pkg::KIND_MATCH;
            case ($urandom_range(0, 3))
               0: kind = KIND_UNUSED;
               1: distance = '0;
               2: distance = (bytes_held >= 65535) ? '0 :
                             lzme_pkg::DIST_W'($urandom_range(bytes_held + 1, 65535));
               default: begin
                  distance = (bytes_held > 0) ?
                             lzme_pkg::DIST_W'($urandom_range(1, bytes_held)) : '0;
                  len      = '0;
               end
            endcase
         end
         send_request(kind, data, distance, len, 1'b0, '0);
      end

      // matches reaching towards the far end of the window, with a literal every fifth request
      for (int n = 0; n < DEEP_MATCHES; n++) begin
         case ($urandom_range(0, 4))
            0: distance = lzme_pkg::DIST_W'(WINDOW);
            1: distance = lzme_pkg::DIST_W'(WINDOW - 1);
            2: distance = lzme_pkg::DIST_W'(WINDOW + 1);
            default: distance = lzme_pkg::DIST_W'($urandom_range(1, WINDOW));
         endcase
         if (n % 5 == 4)
            send_request(lzme_pkg::KIND_LITERAL, lzme_pkg::DATA_W'($urandom),
                         lzme_pkg::DIST_W'($urandom), lzme_pkg::LEN_W'($urandom),
                         1'b0, '0);
         else
            send_request(lzme_pkg::KIND_MATCH, lzme_pkg::DATA_W'($urandom), distance,
                         lzme_pkg::LEN_W'($urandom_range(1, 127)), 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      // drain, then let the back end settle
      while (expected_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Result side: random back-pressure and one long hold-off
   initial begin
      decoded_type want;
      int          pause;
      rsp_tready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         pause = rsp_calm ? 0 : $urandom_range(0, 10);
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end else if (pause > 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         // compare the accepted result with the oldest expectation
         if (expected_bytes.size() == 0) begin
            $error("unexpected result: out_byte %02h last %0b error %0b",
                   rsp_tdata, rsp_tlast, rsp_tuser);
            failures++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_tdata);
               failures++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_tlast);
               failures++;
            end
            if (rsp_tuser !== want.error) begin
               $error("error: expected %0b, got %0b", want.error, rsp_tuser);
               failures++;
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
         if (stalled_cycles == WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/lzme_pkg.sv
hdl/lzme_ram.sv
hdl/lzme_front.sv
hdl/lzme_cmd_fifo.sv
hdl/lzme_back.sv
hdl/lz77_dictionary_match_expander_unit.sv
hdl/lzme_checker.sv
tb/sv/testbench.sv
